// ===== rtl/rps_pkg.sv =====
`default_nettype none
package rps_pkg;

  // page geometry
  localparam int MIN_PAGE_SHIFT = 12;
  localparam int ADDR_BITS      = 64;
  localparam int PAGES_PER_ITEM = 64;

  localparam logic [63:0] MIN_PAGE  = 64'(1) << MIN_PAGE_SHIFT;
  localparam logic [63:0] PAGE_OFS  = MIN_PAGE - 64'(1);
  localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_BITS);
  localparam logic [63:0] LEN_CAP   = ADDR_MASK & ~PAGE_OFS;
  localparam logic [64:0] TOT_LIMIT = {1'b0, ADDR_MASK - PAGE_OFS};

  // page counter holds 0 .. PAGES_PER_ITEM
  localparam int CNT_W = $clog2(PAGES_PER_ITEM + 1);

  // size search: SCAN_W candidate shifts per cycle, highest group first
  localparam int SHIFT_W = 6;
  localparam int SCAN_LW = 3;
  localparam int SCAN_W  = 1 << SCAN_LW;
  localparam int GRP_W   = SHIFT_W - SCAN_LW;

  // region command carried in the input tuser
  typedef enum logic {
    CMD_NEW      = 1'b0,
    CMD_CONTINUE = 1'b1
  } rps_cmd_t;

  // input transfer payload, last field in the low bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [2:0]  access_rights;
    logic [7:0]  mem_attributes;
    logic [63:0] region_length;
    logic [63:0] phys_start;
    logic [63:0] virt_start;
  } rps_in_t;

  // result transfer payload, last field in the low bits
  typedef struct packed {
    logic [6:0]         pad;
    logic [2:0]         page_rights;
    logic [7:0]         page_attributes;
    logic [SHIFT_W-1:0] page_order;
    logic [63:0]        page_phys;
    logic [63:0]        page_virt;
  } rps_out_t;

  // result flags carried in tuser
  typedef struct packed {
    logic no_fit_error;
    logic more_pending;
  } rps_flags_t;

endpackage
`default_nettype wire

// ===== rtl/region_page_splitter_top.sv =====
`default_nettype none
// channel | dir | handshake           | payload
// --------+-----+---------------------+----------------------------------------------
// in_     | in  | in_tvalid/in_tready | tuser cmd; tdata region (virt, phys, len, ...)
// out_    | out | out_tvalid/tready   | tdata page; tlast; tuser more_pending, error
// cfg_    | in  | cfg_valid/cfg_ready | cfg_data supported_size_mask
//
// A new region rounds its length on the shared 65-bit adder in ST_SETUP1 and
// ST_SETUP2. Each page then passes a check, a search (8 candidate sizes a cycle
// from the largest down), a transfer load and 3 adds on the shared adder.
// An item emits up to PAGES_PER_ITEM pages; in_tready is high only between items.
// A finished page waits in the output register; a stalled out_tready holds the
// sequencer before it loads the next page. Reset (rst_n, synchronous) clears control
// state, the kept remainder length and the size mask to the 4 KiB page only.
module region_page_splitter_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // lsb up: virt_start, phys_start, region_length, mem_attributes, access_rights, zeros
  input  wire logic [207:0] in_tdata,
  // cmd
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // lsb up: page_virt, page_phys, page_order, page_attributes, page_rights, zeros
  output logic [151:0]      out_tdata,
  output logic              out_tlast,
  // lsb up: more_pending, no_fit_error
  output logic [1:0]        out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [63:0]  cfg_data
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SETUP1 = 4'd1;
  localparam logic [3:0] ST_SETUP2 = 4'd2;
  localparam logic [3:0] ST_CHECK  = 4'd3;
  localparam logic [3:0] ST_SEARCH = 4'd4;
  localparam logic [3:0] ST_EMIT   = 4'd5;
  localparam logic [3:0] ST_ERR    = 4'd6;
  localparam logic [3:0] ST_ADV_V  = 4'd7;
  localparam logic [3:0] ST_ADV_P  = 4'd8;
  localparam logic [3:0] ST_ADV_L  = 4'd9;

  rps_pkg::rps_in_t  in_w;
  rps_pkg::rps_out_t out_r, out_nxt;
  rps_pkg::rps_flags_t flags_r, flags_nxt;

  logic [3:0]                  state_r, state_nxt;
  logic [63:0]                 mask_r;
  logic [63:0]                 rem_virt_r, rem_virt_nxt;
  logic [63:0]                 rem_phys_r, rem_phys_nxt;
  logic [63:0]                 rem_len_r, rem_len_nxt;
  logic [7:0]                  attr_r, attr_nxt;
  logic [2:0]                  rights_r, rights_nxt;
  logic [64:0]                 tot_r, tot_nxt;
  logic [rps_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [rps_pkg::GRP_W-1:0]   grp_r, grp_nxt;
  logic                        len_hi_r, len_hi_nxt;
  logic [rps_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        tlast_r, tlast_nxt;

  // shared adder
  logic [64:0] op_a, op_b, add_res;
  logic        op_sub;

  // search unit
  logic [rps_pkg::SCAN_W-1:0]  grp_len;
  logic [rps_pkg::SCAN_W-1:0]  hit_vec;
  logic [rps_pkg::SCAN_LW-1:0] hit_pos;
  logic [rps_pkg::SHIFT_W-1:0] s_idx;
  logic [63:0]                 vp_or;
  logic [63:0]                 low_mask;
  logic [63:0]                 page_sz;
  logic                        out_free;
  logic                        emit_last;

  assign in_w       = in_tdata;
  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign out_tlast  = tlast_r;
  assign out_tuser  = flags_r;

  assign out_free = !out_valid_r || out_tready;
  assign page_sz  = 64'(1) << shift_r;
  assign vp_or    = rem_virt_r | rem_phys_r;
  assign add_res  = op_a + (op_sub ? ~op_b : op_b) + 65'(op_sub);
  assign emit_last = (rem_len_r == page_sz) ||
                     (cnt_r == rps_pkg::CNT_W'(rps_pkg::PAGES_PER_ITEM - 1));

  // adder operand select
  always_comb begin
    op_a   = tot_r;
    op_b   = {1'b0, rem_len_r};
    op_sub = 1'b0;
    case (state_r)
      ST_SETUP2: begin
        op_b = {1'b0, rps_pkg::PAGE_OFS};
      end
      ST_ADV_V: begin
        op_a = {1'b0, rem_virt_r};
        op_b = {1'b0, page_sz};
      end
      ST_ADV_P: begin
        op_a = {1'b0, rem_phys_r};
        op_b = {1'b0, page_sz};
      end
      ST_ADV_L: begin
        op_a   = {1'b0, rem_len_r};
        op_b   = {1'b0, page_sz};
        op_sub = 1'b1;
      end
      default: begin
        op_a = tot_r;
      end
    endcase
  end

  // one group of candidate sizes per cycle
  always_comb begin
    grp_len = rem_len_r[{grp_r, rps_pkg::SCAN_LW'(0)} +: rps_pkg::SCAN_W];
    hit_pos = '0;
    s_idx   = '0;
    for (int i = 0; i < rps_pkg::SCAN_W; i++) begin
      s_idx      = {grp_r, rps_pkg::SCAN_LW'(i)};
      low_mask   = ~({64{1'b1}} << s_idx);
      hit_vec[i] = mask_r[s_idx] && (s_idx != '0) && ((vp_or & low_mask) == '0) &&
                   (len_hi_r || (|(grp_len >> i)));
    end
    for (int i = 0; i < rps_pkg::SCAN_W; i++) begin
      if (hit_vec[i]) begin
        hit_pos = rps_pkg::SCAN_LW'(i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rem_virt_nxt  = rem_virt_r;
    rem_phys_nxt  = rem_phys_r;
    rem_len_nxt   = rem_len_r;
    attr_nxt      = attr_r;
    rights_nxt    = rights_r;
    tot_nxt       = tot_r;
    cnt_nxt       = cnt_r;
    grp_nxt       = grp_r;
    len_hi_nxt    = len_hi_r;
    shift_nxt     = shift_r;
    out_nxt       = out_r;
    flags_nxt     = flags_r;
    tlast_nxt     = tlast_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cnt_nxt = '0;
          if (in_tuser == rps_pkg::CMD_NEW) begin
            rem_virt_nxt = in_w.virt_start & rps_pkg::LEN_CAP;
            rem_phys_nxt = in_w.phys_start & rps_pkg::LEN_CAP;
            rem_len_nxt  = in_w.region_length;
            attr_nxt     = in_w.mem_attributes;
            rights_nxt   = in_w.access_rights;
            tot_nxt      = {1'b0, in_w.virt_start & rps_pkg::ADDR_MASK & rps_pkg::PAGE_OFS};
            state_nxt    = ST_SETUP1;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_SETUP1: begin
        tot_nxt   = add_res;
        state_nxt = ST_SETUP2;
      end
      ST_SETUP2: begin
        rem_len_nxt = (tot_r > rps_pkg::TOT_LIMIT) ? rps_pkg::LEN_CAP
                                                   : add_res[63:0] & ~rps_pkg::PAGE_OFS;
        state_nxt   = ST_CHECK;
      end
      ST_CHECK: begin
        grp_nxt    = '1;
        len_hi_nxt = 1'b0;
        if (rem_len_r == '0 ||
            cnt_r == rps_pkg::CNT_W'(rps_pkg::PAGES_PER_ITEM)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (|hit_vec) begin
          shift_nxt = {grp_r, hit_pos};
          state_nxt = ST_EMIT;
        end else if (grp_r == '0) begin
          state_nxt = ST_ERR;
        end else begin
          grp_nxt    = grp_r - rps_pkg::GRP_W'(1);
          len_hi_nxt = len_hi_r || (|grp_len);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_nxt.pad                = '0;
          out_nxt.page_rights        = rights_r;
          out_nxt.page_attributes    = attr_r;
          out_nxt.page_order         = shift_r;
          out_nxt.page_phys          = rem_phys_r;
          out_nxt.page_virt          = rem_virt_r;
          flags_nxt.no_fit_error     = 1'b0;
          flags_nxt.more_pending     = emit_last && (rem_len_r != page_sz);
          tlast_nxt                  = emit_last;
          out_valid_nxt              = 1'b1;
          cnt_nxt                    = cnt_r + rps_pkg::CNT_W'(1);
          state_nxt                  = ST_ADV_V;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_nxt                = '0;
          flags_nxt.no_fit_error = 1'b1;
          flags_nxt.more_pending = 1'b0;
          tlast_nxt              = 1'b1;
          out_valid_nxt          = 1'b1;
          rem_len_nxt            = '0;
          rem_virt_nxt           = '0;
          rem_phys_nxt           = '0;
          state_nxt              = ST_IDLE;
        end
      end
      ST_ADV_V: begin
        rem_virt_nxt = add_res[63:0] & rps_pkg::ADDR_MASK;
        state_nxt    = ST_ADV_P;
      end
      ST_ADV_P: begin
        rem_phys_nxt = add_res[63:0] & rps_pkg::ADDR_MASK;
        state_nxt    = ST_ADV_L;
      end
      ST_ADV_L: begin
        rem_len_nxt = add_res[63:0];
        state_nxt   = ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rem_len_r   <= '0;
      mask_r      <= rps_pkg::MIN_PAGE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rem_len_r   <= rem_len_nxt;
      if (cfg_valid) begin
        mask_r <= cfg_data;
      end
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    rem_virt_r <= rem_virt_nxt;
    rem_phys_r <= rem_phys_nxt;
    attr_r     <= attr_nxt;
    rights_r   <= rights_nxt;
    tot_r      <= tot_nxt;
    cnt_r      <= cnt_nxt;
    grp_r      <= grp_nxt;
    len_hi_r   <= len_hi_nxt;
    shift_r    <= shift_nxt;
    out_r      <= out_nxt;
    flags_r    <= flags_nxt;
    tlast_r    <= tlast_nxt;
  end

  // error result carries no page and ends the item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && flags_r.no_fit_error |-> tlast_r && out_r.page_order == '0 &&
      !flags_r.more_pending)
    else $error("error result not final or not cleared");

  // a kept remainder is only flagged on the final page
  a_more_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && flags_r.more_pending |-> tlast_r)
    else $error("more_pending without last");

  // a page always uses a supported size above one byte
  a_size_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !flags_r.no_fit_error |-> out_r.page_order != '0 &&
      mask_r[out_r.page_order])
    else $error("page size not supported");

  // page budget per item
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> cnt_r <= rps_pkg::CNT_W'(rps_pkg::PAGES_PER_ITEM))
    else $error("page count over budget");

  // an accepted item is worked on before the next transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken back to back");

endmodule
`default_nettype wire

// ===== verif/region_page_splitter_top_tb.sv =====
`timescale 1ns / 100ps

module region_page_splitter_top_tb;

  localparam logic [63:0] PAGE_LO  = (64'd1 << rps_pkg::MIN_PAGE_SHIFT) - 64'd1;
  localparam logic [63:0] ADDR_ALL = {64{1'b1}} >> (64 - rps_pkg::ADDR_BITS);
  localparam logic [63:0] LEN_SAT  = ADDR_ALL & ~PAGE_LO;
  localparam int SETTLE_CYCLES = 40;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_THROTTLE
  } rx_mode_t;

  typedef struct packed {
    rps_pkg::rps_cmd_t cmd;
    logic [63:0] virt;
    logic [63:0] phys;
    logic [63:0] len;
    logic [7:0]  attr;
    logic [2:0]  rights;
  } region_req_t;

  typedef struct packed {
    logic [63:0] virt;
    logic [63:0] phys;
    logic [5:0]  shift;
    logic [7:0]  attr;
    logic [2:0]  rights;
    logic        last;
    logic        more;
    logic        err;
  } page_map_t;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [207:0] in_tdata   = '0;
  logic         in_tuser   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic         out_tlast;
  logic [1:0]   out_tuser;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [63:0]  cfg_data   = '0;

  // region still to be mapped, as the block should hold it
  logic [63:0] size_mask   = 64'h1000;
  logic [63:0] held_virt   = '0;
  logic [63:0] held_phys   = '0;
  logic [63:0] held_len    = '0;
  logic [7:0]  held_attr   = '0;
  logic [2:0]  held_rights = '0;

  region_req_t pending_regions[$];
  page_map_t   expected_pages[$];

  int          mismatch_count = 0;
  int          pages_seen     = 0;
  int          burst_left     = 0;
  int          gap_left       = 0;
  logic        drain_hold     = 1'b0;
  rx_mode_t    ready_mode     = RX_STEADY;
  int          ready_left     = 0;
  int unsigned ready_tick     = 0;

  region_page_splitter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // largest supported size aligned for both addresses and not above the length
  function automatic int unsigned best_shift(input logic [63:0] v, input logic [63:0] p,
                                             input logic [63:0] len);
    for (int s = 63; s >= 1; s--) begin
      if (size_mask[s] && len >= (64'd1 << s) && ((v | p) & ((64'd1 << s) - 64'd1)) == 0)
        return s;
    end
    return 0;
  endfunction

  // expected pages for one accepted region or continue transfer
  task automatic split_pages(input region_req_t r);
    logic [63:0] off;
    logic [63:0] total;
    logic [63:0] sz;
    int unsigned sh;
    int          n;
    page_map_t   pg;
    n = 0;
    if (r.cmd == rps_pkg::CMD_NEW) begin
      off = r.virt & ADDR_ALL & PAGE_LO;
      if (r.len > ADDR_ALL - off) begin
        total = LEN_SAT;
      end else begin
        total = off + r.len;
        if (total > ADDR_ALL - PAGE_LO) total = LEN_SAT;
        else total = (total + PAGE_LO) & ~PAGE_LO;
      end
      held_virt   = r.virt & ADDR_ALL & ~PAGE_LO;
      held_phys   = r.phys & ADDR_ALL & ~PAGE_LO;
      held_len    = total;
      held_attr   = r.attr;
      held_rights = r.rights;
    end
    while (held_len != 0 && n < rps_pkg::PAGES_PER_ITEM) begin
      sh = best_shift(held_virt, held_phys, held_len);
      pg = '0;
      if (sh == 0) begin
        // nothing fits: error page, remainder dropped
        pg.err    = 1'b1;
        held_len  = '0;
        held_virt = '0;
        held_phys = '0;
      end else begin
        sz        = 64'd1 << sh;
        pg.virt   = held_virt;
        pg.phys   = held_phys;
        pg.shift  = 6'(sh);
        pg.attr   = held_attr;
        pg.rights = held_rights;
        held_virt = (held_virt + sz) & ADDR_ALL;
        held_phys = (held_phys + sz) & ADDR_ALL;
        held_len  = held_len - sz;
      end
      expected_pages.push_back(pg);
      n++;
    end
    // mark the final page of this transfer
    if (n > 0) begin
      pg      = expected_pages.pop_back();
      pg.last = 1'b1;
      pg.more = (held_len != 0);
      expected_pages.push_back(pg);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("[%0t] page %0d %s: got %h expected %h", $time, pages_seen, field, got, want);
  endtask

  task automatic push_region(input rps_pkg::rps_cmd_t c, input logic [63:0] v,
                             input logic [63:0] p, input logic [63:0] len,
                             input logic [7:0] a, input logic [2:0] r);
    region_req_t q;
    q.cmd    = c;
    q.virt   = v;
    q.phys   = p;
    q.len    = len;
    q.attr   = a;
    q.rights = r;
    pending_regions.push_back(q);
  endtask

  // well-formed regions with random geometry, plus continues and noise
  task automatic queue_random_regions(input int count);
    int unsigned al;
    int unsigned pick;
    int unsigned conts;
    logic [63:0] amask;
    logic [63:0] v;
    logic [63:0] p;
    logic [63:0] len;
    repeat (count) begin
      al    = $urandom_range(12, 44);
      amask = (64'd1 << al) - 64'd1;
      v     = {$urandom, $urandom};
      p     = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 80) begin
        v = v & ~amask;
        p = p & ~amask;
        if ($urandom_range(0, 3) == 0) begin
          v = v | 64'($urandom_range(0, 4095));
          p = p | 64'($urandom_range(0, 4095));
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) len = '0;
      else if (pick < 60) len = 64'($urandom_range(1, 96) * 4096 - $urandom_range(0, 4095));
      else if (pick < 88) len = (64'd1 << $urandom_range(12, 40)) * 64'($urandom_range(1, 5));
      else len = {$urandom, $urandom};
      push_region(rps_pkg::CMD_NEW, v, p, len, 8'($urandom_range(0, 255)),
                  3'($urandom_range(0, 7)));
      // continues for long regions, now and then one too many
      conts = ((len >> 18) > 3) ? 3 : int'(len >> 18);
      if ($urandom_range(0, 9) == 0) conts++;
      repeat (conts)
        push_region(rps_pkg::CMD_CONTINUE, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, 8'($urandom), 3'($urandom));
    end
  endtask

  // wait until everything sent has come back and the block has gone quiet
  task automatic drain_and_settle();
    while (pending_regions.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_pages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size_mask(input logic [63:0] m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_mask = m;
  endtask

  // input driver: bursts and gaps, occasionally holds until all pages are back
  always @(posedge clk) begin
    rps_pkg::rps_in_t word;
    region_req_t      taken;
    logic             present;
    logic             hold;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      present = 1'b0;
      hold    = in_tvalid && !in_tready;
      if (in_tvalid && in_tready) begin
        taken = pending_regions.pop_front();
        split_pages(taken);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          drain_hold = ($urandom_range(0, 15) == 0);
        end
      end
      if (hold) begin
        present = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (drain_hold) begin
        if (expected_pages.size() == 0) drain_hold = 1'b0;
      end else if (pending_regions.size() != 0) begin
        present             = 1'b1;
        word.pad            = '0;
        word.access_rights  = pending_regions[0].rights;
        word.mem_attributes = pending_regions[0].attr;
        word.region_length  = pending_regions[0].len;
        word.phys_start     = pending_regions[0].phys;
        word.virt_start     = pending_regions[0].virt;
        in_tdata <= word;
        in_tuser <= pending_regions[0].cmd;
      end
      in_tvalid <= present;
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    rps_pkg::rps_out_t   got;
    rps_pkg::rps_flags_t flags;
    page_map_t           want;
    logic                next_ready;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got   = rps_pkg::rps_out_t'(out_tdata);
        flags = rps_pkg::rps_flags_t'(out_tuser);
        if (expected_pages.size() == 0) begin
          report_mismatch("unexpected transfer, page_virt", got.page_virt, '0);
        end else begin
          want = expected_pages.pop_front();
          if (got.page_virt !== want.virt)
            report_mismatch("page_virt", got.page_virt, want.virt);
          if (got.page_phys !== want.phys)
            report_mismatch("page_phys", got.page_phys, want.phys);
          if (got.page_order !== want.shift)
            report_mismatch("page_order", 64'(got.page_order), 64'(want.shift));
          if (got.page_attributes !== want.attr)
            report_mismatch("page_attributes", 64'(got.page_attributes), 64'(want.attr));
          if (got.page_rights !== want.rights)
            report_mismatch("page_rights", 64'(got.page_rights), 64'(want.rights));
          if (out_tlast !== want.last)
            report_mismatch("last", 64'(out_tlast), 64'(want.last));
          if (flags.more_pending !== want.more)
            report_mismatch("more_pending", 64'(flags.more_pending), 64'(want.more));
          if (flags.no_fit_error !== want.err)
            report_mismatch("no_fit_error", 64'(flags.no_fit_error), 64'(want.err));
        end
        pages_seen++;
      end
      if (ready_left == 0) begin
        ready_mode = rx_mode_t'($urandom_range(0, 2));
        ready_left = $urandom_range(16, 160);
      end else begin
        ready_left--;
      end
      case (ready_mode)
        RX_STEADY:   next_ready = 1'b1;
        RX_RANDOM:   next_ready = ($urandom_range(0, 1) == 1);
        default:     next_ready = (ready_tick % 3 == 0);
      endcase
      ready_tick++;
      out_tready <= next_ready;
    end
  end

  // stimulus sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset mask, min pages only: empty cases, straddle, wrap, split and saturation
    push_region(rps_pkg::CMD_NEW, 64'h0, 64'h0, 64'h0, 8'h00, 3'd0);
    push_region(rps_pkg::CMD_CONTINUE, '1, '1, '1, 8'hFF, 3'd7);
    push_region(rps_pkg::CMD_NEW, 64'h0000_1234_5678_9FFF, 64'h8000_0000_0000_0ABC, 64'd2,
                8'hFF, 3'd7);
    push_region(rps_pkg::CMD_NEW, 64'hFFFF_FFFF_FFFF_F000, 64'h0000_0000_0000_1000, 64'd8192,
                8'h5A, 3'd5);
    push_region(rps_pkg::CMD_NEW, 64'h0001_0000, 64'h0002_0000, 64'd65 * 64'd4096,
                8'h33, 3'd1);
    push_region(rps_pkg::CMD_CONTINUE, '0, '0, '0, 8'h00, 3'd0);
    push_region(rps_pkg::CMD_NEW, 64'h0, 64'h0, '1, 8'hA5, 3'd2);
    push_region(rps_pkg::CMD_CONTINUE, '0, '0, '0, 8'h00, 3'd0);
    push_region(rps_pkg::CMD_NEW, 64'h3000, 64'h5000, 64'd4096, 8'h81, 3'd6);
    push_region(rps_pkg::CMD_NEW, 64'h0800, 64'hFFFF_0000_0000_0000, 64'hFFFF_FFFF_FFFF_F800,
                8'h01, 3'd3);
    push_region(rps_pkg::CMD_NEW, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_F001, 8'h7E, 3'd4);
    drain_and_settle();

    // every size supported: largest pages first
    write_size_mask('1);
    push_region(rps_pkg::CMD_NEW, 64'h0, 64'h0, '1, 8'hC3, 3'd7);
    push_region(rps_pkg::CMD_NEW, 64'h4000_0000, 64'h8000_0000, (64'd1 << 30) + 64'd4096,
                8'h10, 3'd1);
    push_region(rps_pkg::CMD_NEW, 64'h1000, 64'h3000, 64'h10_0000, 8'h20, 3'd2);
    drain_and_settle();

    // no size supported
    write_size_mask('0);
    push_region(rps_pkg::CMD_NEW, 64'h1000, 64'h2000, 64'd4096, 8'hFF, 3'd7);
    push_region(rps_pkg::CMD_CONTINUE, '0, '0, '0, 8'h00, 3'd0);
    push_region(rps_pkg::CMD_NEW, 64'h1000, 64'h2000, 64'd0, 8'hFF, 3'd7);
    drain_and_settle();

    // byte size only, which is never chosen
    write_size_mask(64'h1);
    push_region(rps_pkg::CMD_NEW, 64'h0, 64'h0, 64'd1, 8'h44, 3'd4);
    drain_and_settle();

    // top size only: one page then no fit
    write_size_mask(64'h8000_0000_0000_0000);
    push_region(rps_pkg::CMD_NEW, 64'h0, 64'h0, '1, 8'h99, 3'd5);
    push_region(rps_pkg::CMD_NEW, 64'h8000_0000_0000_0000, 64'h0, 64'h8000_0000_0000_0000,
                8'h66, 3'd2);
    drain_and_settle();

    // 8 KiB only: fit then no fit, and misaligned start
    write_size_mask(64'h2000);
    push_region(rps_pkg::CMD_NEW, 64'h2000, 64'h4000, 64'h3000, 8'h0F, 3'd6);
    push_region(rps_pkg::CMD_NEW, 64'h1000, 64'h0, 64'h4000, 8'hF0, 3'd1);
    drain_and_settle();

    // random regions under several size sets
    write_size_mask(64'h0000_0000_4020_7000);
    queue_random_regions(30);
    drain_and_settle();

    write_size_mask(({$urandom, $urandom} & 64'h0000_FFFF_FFFF_F000) | 64'h1000);
    queue_random_regions(30);
    drain_and_settle();

    write_size_mask('1);
    queue_random_regions(25);
    drain_and_settle();

    write_size_mask({$urandom, $urandom});
    queue_random_regions(20);
    drain_and_settle();

    write_size_mask(64'h1000);
    queue_random_regions(20);
    drain_and_settle();

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== region_page_splitter_top.f =====
rtl/rps_pkg.sv
rtl/region_page_splitter_top.sv
verif/region_page_splitter_top_tb.sv
